@@ design/cddm_pkg.sv @@
// Package for the channel deframer / demultiplexer.
// Holds sizes, input and result codes, the queued command type and id helpers.
// No dependencies.
package cddm_pkg;

  // Number of client channels, ids 1..MAX_CHANNELS
  localparam int MAX_CHANNELS = 16;
  // Slot index width (id minus one) and free-count width
  localparam int IDW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // Input item kinds
  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_UP    = 3'd3,
    KIND_DOWN  = 3'd4
  } kind_e;

  // Result kinds
  typedef enum logic [1:0] {
    RES_PAYLOAD  = 2'd0,
    RES_ACCEPT   = 2'd1,
    RES_REFUSE   = 2'd2,
    RES_SHUTDOWN = 2'd3
  } res_kind_e;

  // Commands passed from front to back
  typedef enum logic [2:0] {
    OP_BYTE,
    OP_OPEN,
    OP_CLOSE,
    OP_UP,
    OP_DOWN
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] arg;   // stream byte (low bits) or channel id to close
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Channel id for a slot index
  function automatic logic [15:0] id_of(input logic [IDW-1:0] slot);
    id_of = 16'(slot) + 16'd1;
  endfunction

  // Slot index for a channel id (valid only when the id is in range)
  function automatic logic [IDW-1:0] slot_of(input logic [15:0] id);
    logic [15:0] tmp;
    tmp = id - 16'd1;
    slot_of = tmp[IDW-1:0];
  endfunction

  // True for ids 1..MAX_CHANNELS
  function automatic logic id_in_range(input logic [15:0] id);
    id_in_range = (id != 16'd0) && (id <= 16'(MAX_CHANNELS));
  endfunction

endpackage

@@ design/cddm_front.sv @@
// Front part: accepts input items and classifies them into commands.
// Depends on cddm_pkg. Feeds cddm_queue.
module cddm_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           kind_i,
  input  logic [7:0]           data_byte_i,
  input  logic [15:0]          close_channel_i,
  input  cddm_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output cddm_pkg::cmd_t       cmd_o
);
  import cddm_pkg::*;

  logic known;

  // Stall only when the queue has no room
  assign in_stall_o = q_status_i.full;

  // Decode kind; unused kinds are accepted and dropped
  always_comb begin
    known      = 1'b1;
    cmd_o.op   = OP_BYTE;
    cmd_o.arg  = 16'd0;
    case (kind_e'(kind_i))
      KIND_BYTE: begin
        cmd_o.op  = OP_BYTE;
        cmd_o.arg = {8'd0, data_byte_i};
      end
      KIND_OPEN:  cmd_o.op = OP_OPEN;
      KIND_CLOSE: begin
        cmd_o.op  = OP_CLOSE;
        cmd_o.arg = close_channel_i;
      end
      KIND_UP:    cmd_o.op = OP_UP;
      KIND_DOWN:  cmd_o.op = OP_DOWN;
      default:    known = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && !q_status_i.full && known;

endmodule

@@ design/cddm_queue.sv @@
// Short command queue between front and back.
// Depends on cddm_pkg.
module cddm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cddm_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output cddm_pkg::cmd_t       head_o,
  output cddm_pkg::q_status_t  status_o
);
  import cddm_pkg::*;

  cmd_t           entry_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q;
  logic           do_push, do_pop;

  assign status_o.full  = (cnt_q == QCW'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = entry_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= cmd_i;
  end

endmodule

@@ design/cddm_back.sv @@
// Back part: executes commands against the channel state, runs the packet
// parser and the shutdown sweep, and holds the output register. Uses cddm_pkg.
module cddm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cddm_pkg::cmd_t       cmd_i,
  input  cddm_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           result_kind_o,
  output logic [15:0]          channel_o,
  output logic [7:0]           payload_o,
  output logic                 packet_end_o,
  output logic                 last_o
);
  import cddm_pkg::*;

  typedef enum logic [1:0] {
    HDR_LEN,
    HDR_CH_LO,
    HDR_CH_HI,
    HDR_BODY
  } hdr_e;

  // Channel state
  logic                    up_q, up_d;
  logic [IDW-1:0]          head_q, head_d;
  logic [CW-1:0]           count_q, count_d;
  logic [MAX_CHANNELS-1:0] open_q, open_d;
  logic [MAX_CHANNELS-1:0] ovr_q, ovr_d;   // slot rewritten since last refill
  logic [IDW-1:0]          mem_q [MAX_CHANNELS];
  // Parser state
  hdr_e                    hpos_q, hpos_d;
  logic [7:0]              len_q, len_d;
  logic [15:0]             pch_q, pch_d;
  logic [7:0]              left_q, left_d;
  // Output register
  logic                    ovalid_q;
  res_kind_e               rk_q, rk_d;
  logic [15:0]             ch_q, ch_d;
  logic [7:0]              pay_q, pay_d;
  logic                    pend_q, pend_d;
  logic                    last_q, last_d;

  logic                    load_ok, go, emit;
  logic                    mem_we;
  logic [IDW-1:0]          mem_wa, mem_wd;
  logic [IDW-1:0]          head_slot, ff_slot, tail;
  logic [CW:0]             tail_sum;
  logic [MAX_CHANNELS-1:0] rest;
  logic [7:0]              left_dec;
  logic                    pkt_open, close_ok;

  assign load_ok = !ovalid_q || !out_stall_i;
  assign go      = !q_status_i.empty && load_ok;

  // Slot handed out by the free FIFO: refilled slots hold their own index
  assign head_slot = ovr_q[head_q] ? mem_q[head_q] : head_q;

  // Tail of the free FIFO
  always_comb begin
    tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
    if (tail_sum >= (CW+1)'(MAX_CHANNELS)) tail_sum = tail_sum - (CW+1)'(MAX_CHANNELS);
    tail = tail_sum[IDW-1:0];
  end

  // Lowest open channel for the shutdown sweep
  always_comb begin
    ff_slot = '0;
    for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
      if (open_q[i]) ff_slot = IDW'(i);
    end
    rest = open_q;
    rest[ff_slot] = 1'b0;
  end

  assign left_dec = left_q - 8'd1;
  assign pkt_open = id_in_range(pch_q) && open_q[slot_of(pch_q)];
  assign close_ok = up_q && id_in_range(cmd_i.arg) && open_q[slot_of(cmd_i.arg)] &&
                    (count_q < CW'(MAX_CHANNELS));

  // Command execution
  always_comb begin
    up_d    = up_q;
    head_d  = head_q;
    count_d = count_q;
    open_d  = open_q;
    ovr_d   = ovr_q;
    hpos_d  = hpos_q;
    len_d   = len_q;
    pch_d   = pch_q;
    left_d  = left_q;
    emit    = 1'b0;
    rk_d    = RES_PAYLOAD;
    ch_d    = 16'd0;
    pay_d   = 8'd0;
    pend_d  = 1'b0;
    last_d  = 1'b1;
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = tail;
    mem_wd  = slot_of(cmd_i.arg);
    if (go) begin
      case (cmd_i.op)
        OP_BYTE: begin
          pop_o = 1'b1;
          if (up_q) begin
            case (hpos_q)
              HDR_LEN: begin
                len_d  = cmd_i.arg[7:0];
                hpos_d = HDR_CH_LO;
              end
              HDR_CH_LO: begin
                pch_d  = {8'd0, cmd_i.arg[7:0]};
                hpos_d = HDR_CH_HI;
              end
              HDR_CH_HI: begin
                pch_d  = {cmd_i.arg[7:0], pch_q[7:0]};
                left_d = len_q;
                hpos_d = (len_q != 8'd0) ? HDR_BODY : HDR_LEN;
              end
              default: begin
                left_d = left_dec;
                if (pkt_open) begin
                  emit   = 1'b1;
                  rk_d   = RES_PAYLOAD;
                  ch_d   = pch_q;
                  pay_d  = cmd_i.arg[7:0];
                  pend_d = (left_dec == 8'd0);
                end
                if (left_dec == 8'd0) hpos_d = HDR_LEN;
              end
            endcase
          end
        end
        OP_OPEN: begin
          pop_o = 1'b1;
          emit  = 1'b1;
          if (count_q != '0) begin
            rk_d    = RES_ACCEPT;
            ch_d    = id_of(head_slot);
            open_d[head_slot] = 1'b1;
            head_d  = (head_q == IDW'(MAX_CHANNELS - 1)) ? '0 : head_q + 1'b1;
            count_d = count_q - 1'b1;
          end else begin
            rk_d = RES_REFUSE;
          end
        end
        OP_CLOSE: begin
          pop_o = 1'b1;
          if (close_ok) begin
            mem_we  = 1'b1;
            ovr_d[tail] = 1'b1;
            count_d = count_q + 1'b1;
            open_d[slot_of(cmd_i.arg)] = 1'b0;
          end
        end
        OP_UP: begin
          pop_o = 1'b1;
          if (!up_q) begin
            up_d    = 1'b1;
            head_d  = '0;
            count_d = CW'(MAX_CHANNELS);
            ovr_d   = '0;
          end
        end
        default: begin
          // Backend down: one shutdown per cycle while the output is not stalled, lowest id first
          if (open_q != '0) begin
            emit   = 1'b1;
            rk_d   = RES_SHUTDOWN;
            ch_d   = id_of(ff_slot);
            last_d = (rest == '0);
            open_d[ff_slot] = 1'b0;
          end
          if (rest == '0) begin
            pop_o   = 1'b1;
            up_d    = 1'b0;
            head_d  = '0;
            count_d = '0;
            hpos_d  = HDR_LEN;
            len_d   = 8'd0;
            pch_d   = 16'd0;
            left_d  = 8'd0;
          end
        end
      endcase
    end
  end

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q     <= 1'b0;
      head_q   <= '0;
      count_q  <= '0;
      open_q   <= '0;
      ovr_q    <= '0;
      hpos_q   <= HDR_LEN;
      len_q    <= 8'd0;
      pch_q    <= 16'd0;
      left_q   <= 8'd0;
      ovalid_q <= 1'b0;
      rk_q     <= RES_PAYLOAD;
      ch_q     <= 16'd0;
      pay_q    <= 8'd0;
      pend_q   <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      up_q    <= up_d;
      head_q  <= head_d;
      count_q <= count_d;
      open_q  <= open_d;
      ovr_q   <= ovr_d;
      hpos_q  <= hpos_d;
      len_q   <= len_d;
      pch_q   <= pch_d;
      left_q  <= left_d;
      if (load_ok) ovalid_q <= emit;
      if (load_ok && emit) begin
        rk_q   <= rk_d;
        ch_q   <= ch_d;
        pay_q  <= pay_d;
        pend_q <= pend_d;
        last_q <= last_d;
      end
    end
  end

  // Free-id store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  assign out_valid_o   = ovalid_q;
  assign result_kind_o = rk_q;
  assign channel_o     = ch_q;
  assign payload_o     = pay_q;
  assign packet_end_o  = pend_q;
  assign last_o        = last_q;

endmodule

@@ design/channel_deframer_demux_unit.sv @@
// Top level of the channel deframer / demultiplexer.
// Depends on cddm_pkg, cddm_front, cddm_queue and cddm_back.
//
// Input channel: in_valid_i / in_stall_o with kind_i, data_byte_i and
// close_channel_i. Kinds: backend byte, client open, client close, backend
// up, backend down; other codes are accepted and dropped.
// Output channel: out_valid_o / out_stall_i with result_kind_o, channel_o,
// payload_o, packet_end_o and last_o; last_o marks the final result of an
// item. An item is taken on an edge where valid is high and stall is low.
// The front writes an accepted item into the command queue; the back part
// then loads its result from the queue head into the output register.
// Throughput: one item per cycle for bytes, opens, closes and backend up,
// while the output is not stalled. Backend down stays at the queue head
// during the shutdown sweep, one result per cycle while not stalled.
// A 4-entry command queue sits between the front and back parts; in_stall_o
// rises only when that queue is full.
// Reset clears the queue, all channel flags, the free-id FIFO count and the
// parser; the backend is down after reset, so opens are refused.
// While out_stall_i is high with a result held, the output register keeps it
// and the back part waits; the queue keeps accepting until it fills.
module channel_deframer_demux_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] close_channel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] channel_o,
  output logic [7:0]  payload_o,
  output logic        packet_end_o,
  output logic        last_o
);
  import cddm_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd, head_cmd;
  logic      push, pop;

  cddm_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .close_channel_i (close_channel_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  cddm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head_cmd),
    .status_o (q_status)
  );

  cddm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .channel_o     (channel_o),
    .payload_o     (payload_o),
    .packet_end_o  (packet_end_o),
    .last_o        (last_o)
  );

endmodule

@@ design/cddm_checker.sv @@
// Port-level checks for channel_deframer_demux_unit, bound to the top level.
// Depends on cddm_pkg.
module cddm_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [15:0] channel_o,
  input logic [7:0]  payload_o,
  input logic        packet_end_o,
  input logic        last_o
);
  import cddm_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
    $stable(channel_o) && $stable(payload_o) && $stable(last_o))
    else $error("stalled result changed");

  // Non-payload results carry no byte and no packet end
  a_nonpay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != RES_PAYLOAD) |-> payload_o == 8'd0 && !packet_end_o)
    else $error("payload fields set on a non-payload result");

  // A payload byte is the only result of its item
  a_pay_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_PAYLOAD) |-> last_o)
    else $error("payload result not marked last");

  // Refused opens name no channel; others name a valid id
  a_refuse_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_REFUSE) |-> channel_o == 16'd0 && last_o)
    else $error("refused open carries a channel");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_ACCEPT || result_kind_o == RES_SHUTDOWN)
    |-> channel_o != 16'd0 && channel_o <= 16'(MAX_CHANNELS))
    else $error("channel id out of range");

endmodule

bind channel_deframer_demux_unit cddm_port_checks u_cddm_port_checks (.*);

@@ tb/sv/cddm_checker.sv @@
// Checker for the channel deframer / demultiplexer: watches both channels,
// predicts the results of each accepted item and compares them in order.
// Depends on cddm_pkg for sizes and input/result codes.
module cddm_checker
  import cddm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] close_channel_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  result_kind_i,
  input  logic [15:0] channel_i,
  input  logic [7:0]  payload_i,
  input  logic        packet_end_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          results_due_o
);

  // Where the stream parser stands within a packet
  typedef enum logic [1:0] {
    HDR_LEN,
    HDR_CH_LO,
    HDR_CH_HI,
    BODY
  } parse_step_e;

  typedef struct packed {
    res_kind_e   kind;
    logic [15:0] ch;
    logic [7:0]  pay;
    logic        pend;
    logic        last;
  } routed_t;

  // Results still owed by the block, oldest first
  routed_t routed_q[$];

  // Shadow state of the block
  logic [15:0] spare_ids [MAX_CHANNELS];
  int unsigned spare_head;
  int unsigned spare_count;
  bit          ch_open [MAX_CHANNELS];
  bit          link_up;
  parse_step_e hdr_step;
  logic [7:0]  frame_len;
  logic [7:0]  frame_left;
  logic [15:0] frame_ch;

  function automatic bit chan_is_open(input logic [15:0] ch);
    if (ch < 16'd1 || ch > 16'(MAX_CHANNELS)) return 1'b0;
    return ch_open[ch - 16'd1];
  endfunction

  // Work out the results of one item and queue them
  task automatic predict_item(input logic [2:0] k, input logic [7:0] b,
                              input logic [15:0] cc);
    routed_t     batch [MAX_CHANNELS];
    int          n;
    int          i;
    int unsigned tail;
    logic [15:0] id;
    n = 0;
    case (k)
      KIND_BYTE: begin
        if (link_up) begin
          case (hdr_step)
            HDR_LEN: begin
              frame_len = b;
              hdr_step = HDR_CH_LO;
            end
            HDR_CH_LO: begin
              frame_ch = {8'h00, b};
              hdr_step = HDR_CH_HI;
            end
            HDR_CH_HI: begin
              frame_ch[15:8] = b;
              frame_left = frame_len;
              hdr_step = (frame_len != 8'd0) ? BODY : HDR_LEN;
            end
            default: begin
              frame_left = frame_left - 8'd1;
              if (chan_is_open(frame_ch)) begin
                batch[n] = '{RES_PAYLOAD, frame_ch, b, frame_left == 8'd0, 1'b0};
                n++;
              end
              if (frame_left == 8'd0) hdr_step = HDR_LEN;
            end
          endcase
        end
      end
      KIND_OPEN: begin
        // Refused when no id is free or the id handed out is not usable
        if (spare_count != 0) begin
          id = spare_ids[spare_head];
          spare_head = (spare_head + 1) % MAX_CHANNELS;
          spare_count--;
          if (id >= 16'd1 && id <= 16'(MAX_CHANNELS)) begin
            ch_open[id - 16'd1] = 1'b1;
            batch[n] = '{RES_ACCEPT, id, 8'h00, 1'b0, 1'b0};
          end else begin
            batch[n] = '{RES_REFUSE, 16'h0000, 8'h00, 1'b0, 1'b0};
          end
        end else begin
          batch[n] = '{RES_REFUSE, 16'h0000, 8'h00, 1'b0, 1'b0};
        end
        n++;
      end
      KIND_CLOSE: begin
        if (link_up && chan_is_open(cc) && spare_count < MAX_CHANNELS) begin
          tail = (spare_head + spare_count) % MAX_CHANNELS;
          spare_ids[tail] = cc;
          spare_count++;
          ch_open[cc - 16'd1] = 1'b0;
        end
      end
      KIND_UP: begin
        // A second backend up leaves the free list alone
        if (!link_up) begin
          link_up = 1'b1;
          spare_head = 0;
          for (i = 0; i < MAX_CHANNELS; i++) spare_ids[i] = 16'(i + 1);
          spare_count = MAX_CHANNELS;
        end
      end
      KIND_DOWN: begin
        // Shutdown sweep in ascending id order, then everything clears
        for (i = 0; i < MAX_CHANNELS; i++) begin
          if (ch_open[i]) begin
            batch[n] = '{RES_SHUTDOWN, 16'(i + 1), 8'h00, 1'b0, 1'b0};
            n++;
            ch_open[i] = 1'b0;
          end
        end
        link_up = 1'b0;
        spare_head = 0;
        spare_count = 0;
        hdr_step = HDR_LEN;
        frame_len = 8'd0;
        frame_ch = 16'd0;
        frame_left = 8'd0;
      end
      default: ;
    endcase
    for (i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      routed_q.insert(routed_q.size(), batch[i]);
    end
  endtask

  // Reset the shadow state, then predict and compare on each handshake
  always @(posedge clk_i or negedge rst_ni) begin
    routed_t want;
    if (!rst_ni) begin
      routed_q.delete();
      foreach (spare_ids[i]) spare_ids[i] = 16'd0;
      foreach (ch_open[i]) ch_open[i] = 1'b0;
      spare_head = 0;
      spare_count = 0;
      link_up = 1'b0;
      hdr_step = HDR_LEN;
      frame_len = 8'd0;
      frame_ch = 16'd0;
      frame_left = 8'd0;
      fail_count_o = 0;
      results_due_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (routed_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: kind %0d ch %0d payload %02h end %0b last %0b",
                     result_kind_i, channel_i, payload_i, packet_end_i, last_i);
        end else begin
          want = routed_q.pop_front();
          if (result_kind_i !== want.kind || channel_i !== want.ch ||
              payload_i !== want.pay || packet_end_i !== want.pend ||
              last_i !== want.last) begin
            fail_count_o++;
            // fields in order: kind / channel / payload / packet end / last
            if (fail_count_o <= 10)
              $display("mismatch: got %0d/%0d/%02h/%0b/%0b expected %0d/%0d/%02h/%0b/%0b",
                       result_kind_i, channel_i, payload_i, packet_end_i, last_i,
                       want.kind, want.ch, want.pay, want.pend, want.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(kind_i, data_byte_i, close_channel_i);
      results_due_o = routed_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the deframer / demultiplexer testbench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict.
// Depends on cddm_pkg, channel_deframer_demux_unit and cddm_checker.
module testbench;
  import cddm_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 40;
  localparam int BIG_LEN = 255;
  localparam int PHASE_ITEMS = 40;
  localparam logic [2:0] KIND_SPARE_MIN = 3'd5;
  localparam logic [2:0] KIND_SPARE_MAX = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [2:0]  kind_i = KIND_BYTE;
  logic [7:0]  data_byte_i = 8'h00;
  logic [15:0] close_channel_i = 16'h0000;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  result_kind_o;
  logic [15:0] channel_o;
  logic [7:0]  payload_o;
  logic        packet_end_o;
  logic        last_o;

  int fail_count;
  int results_due;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  channel_deframer_demux_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .close_channel_i (close_channel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .channel_o       (channel_o),
    .payload_o       (payload_o),
    .packet_end_o    (packet_end_o),
    .last_o          (last_o)
  );

  cddm_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .close_channel_i (close_channel_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_i   (result_kind_o),
    .channel_i       (channel_o),
    .payload_i       (payload_o),
    .packet_end_i    (packet_end_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .results_due_o   (results_due)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when the stimulus asks
  always @(posedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Cycles without any handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item, with random idle cycles ahead of it, until taken
  task automatic offer_item(input logic [2:0] k, input logic [7:0] b,
                            input logic [15:0] cc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    data_byte_i <= b;
    close_channel_i <= cc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (k <= KIND_DOWN) items_sent++;
  endtask

  // Mostly real ids, sometimes id 0 or ids past the top
  function automatic logic [15:0] pick_channel();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 16'($urandom_range(1, MAX_CHANNELS));
    if (r < 92) return 16'h0000;
    return 16'($urandom_range(MAX_CHANNELS + 1, 65535));
  endfunction

  function automatic logic [15:0] pick_close();
    if ($urandom_range(99) < 80) return 16'($urandom_range(1, MAX_CHANNELS));
    return 16'($urandom);
  endfunction

  // Header then body bytes; body below len leaves the packet cut short
  task automatic send_packet(input logic [15:0] ch, input int len, input int body);
    int i;
    offer_item(KIND_BYTE, 8'(len), 16'($urandom));
    offer_item(KIND_BYTE, ch[7:0], 16'($urandom));
    offer_item(KIND_BYTE, ch[15:8], 16'($urandom));
    for (i = 0; i < body; i++) begin
      // opens and closes may land between payload bytes
      if ($urandom_range(99) < 8)
        offer_item($urandom_range(1) ? KIND_OPEN : KIND_CLOSE, 8'($urandom), pick_close());
      offer_item(KIND_BYTE, 8'($urandom), 16'($urandom));
    end
  endtask

  // Stop offering and wait for every owed result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  // One backend session: up, mixed traffic, down
  task automatic run_episode();
    int pick;
    int len;
    offer_item(KIND_UP, 8'($urandom), 16'($urandom));
    // sometimes drain the free list and run past it
    if ($urandom_range(4) == 0)
      repeat (MAX_CHANNELS + 2) offer_item(KIND_OPEN, 8'($urandom), 16'($urandom));
    repeat ($urandom_range(4, 16)) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = ($urandom_range(9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 40);
        send_packet(pick_channel(), len, len);
      end else if (pick < 62) begin
        offer_item(KIND_OPEN, 8'($urandom), 16'($urandom));
      end else if (pick < 77) begin
        offer_item(KIND_CLOSE, 8'($urandom), pick_close());
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: offer_item(3'($urandom_range(KIND_SPARE_MIN, KIND_SPARE_MAX)),
                        8'($urandom), 16'($urandom));
          1: offer_item(KIND_UP, 8'($urandom), 16'($urandom));
          default: offer_item(KIND_BYTE, 8'($urandom), 16'($urandom));
        endcase
      end else begin
        // low ids are handed out first, so these are likely open
        len = $urandom_range(1, 6);
        send_packet(16'($urandom_range(1, 4)), len, len);
      end
    end
    // a packet cut off by the backend going down
    if ($urandom_range(6) == 0)
      send_packet(pick_channel(), 6 + $urandom_range(10), $urandom_range(5));
    offer_item(KIND_DOWN, 8'($urandom), 16'($urandom));
  endtask

  initial begin
    int phase;
    int phase_base;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Backend down: bytes, opens and closes do nothing useful
    offer_item(KIND_BYTE, 8'hFF, 16'hFFFF);
    offer_item(KIND_OPEN, 8'h00, 16'h0000);
    offer_item(KIND_CLOSE, 8'hFF, 16'h0001);
    offer_item(KIND_DOWN, 8'h00, 16'h0000);
    offer_item(KIND_SPARE_MAX, 8'hFF, 16'hFFFF);
    // Up twice; the second must not refill the free list
    offer_item(KIND_UP, 8'h00, 16'h0000);
    offer_item(KIND_UP, 8'hFF, 16'hFFFF);
    repeat (3) offer_item(KIND_OPEN, 8'h00, 16'h0000);
    // Two bytes to id 1, an empty packet, a byte to an id past the top
    send_packet(16'h0001, 2, 2);
    send_packet(16'h0002, 0, 0);
    send_packet(16'hFFFF, 1, 1);
    // Close id 2, then an id out of range
    offer_item(KIND_CLOSE, 8'h00, 16'h0002);
    offer_item(KIND_CLOSE, 8'hFF, 16'hFFFF);
    offer_item(KIND_DOWN, 8'h00, 16'h0000);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      phase_base = items_sent;
      // long receiver hold-off while items keep coming; refused opens
      // each give a result, so the block is sure to fill
      if (phase == 2) begin
        hold_asked++;
        repeat (8) offer_item(KIND_OPEN, 8'($urandom), 16'($urandom));
      end
      // one packet of the largest length to a freshly opened id 1
      if (phase == 3) begin
        offer_item(KIND_UP, 8'($urandom), 16'($urandom));
        offer_item(KIND_OPEN, 8'($urandom), 16'($urandom));
        send_packet(16'h0001, BIG_LEN, BIG_LEN);
        offer_item(KIND_DOWN, 8'($urandom), 16'($urandom));
      end
      while (items_sent < phase_base + PHASE_ITEMS) run_episode();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
